>>> hdl/chained_hash_table_engine_defines.svh
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// Checks that a condition on this cycle implies another on the same cycle.
`define CHTE_ASSERT_NOW(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("chte check failed");

// Checks that a condition on this cycle implies another on the next cycle.
`define CHTE_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("chte check failed");

`endif

>>> hdl/chte_pkg.sv
package chte_pkg;

    localparam int DEF_BUCKETS  = 1024;
    localparam int DEF_CAPACITY = 1024;

    localparam int REQ_W  = 3;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RETRIEVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESET_CUR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_VISIT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_NEXT_DUP  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_KEY_START,
        ST_INS_WR,
        ST_FIND_HEAD,
        ST_FIND_ISSUE,
        ST_FIND_CMP,
        ST_DEL_LINK,
        ST_DEL_FREE,
        ST_CUR_ADV,
        ST_CUR_HEAD,
        ST_CUR_LINK,
        ST_CUR_CHECK,
        ST_VIS_DATA,
        ST_DUP_DATA,
        ST_DUP_ISSUE,
        ST_DUP_CMP,
        ST_OUT
    } state_t;

endpackage

>>> hdl/chained_hash_table_engine.sv
// Chained hash table with bucket heads, links and key/value pairs held in synchronous RAMs.
// Retrieve and delete walk a chain comparing one node at a time, and a delete hit also
// unlinks the node and puts it on the free list. Visit skips empty buckets; a duplicate
// search compares each cursor node with the later nodes of its chain. A BUCKETS that is
// not a power of two adds a reciprocal remainder step before the head lookup.
// One request in flight; after reset every bucket head is cleared before a request is taken.
`include "chained_hash_table_engine_defines.svh"

module chained_hash_table_engine #(
    parameter int BUCKETS  = chte_pkg::DEF_BUCKETS,
    parameter int CAPACITY = chte_pkg::DEF_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [chte_pkg::REQ_W-1:0] req_type,
    input  logic [chte_pkg::KEY_W-1:0] key,
    input  logic [chte_pkg::VAL_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic [chte_pkg::VAL_W-1:0] result_value,
    output logic [chte_pkg::STAT_W-1:0] status
);

    localparam int BW  = $clog2(BUCKETS);
    localparam int CBW = $clog2(BUCKETS + 1);
    localparam int NW  = $clog2(CAPACITY);
    localparam int PW  = $clog2(CAPACITY + 1);
    localparam int KW  = chte_pkg::KEY_W;
    localparam int VW  = chte_pkg::VAL_W;
    localparam int CW  = 2;
    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    // The quotient estimate key * RECIP >> SHIFT is low by at most one.
    localparam int SHIFT = KW + BW;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BUCKETS);
    localparam logic [VW-1:0] RECIP = VW'(RECIP_FULL);
    localparam logic [KW-1:0] BUCKETS_K = KW'(BUCKETS);

    chte_pkg::state_t state_reg, state_next;

    logic [chte_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [KW-1:0]               key_reg, key_next;
    logic [VW-1:0]               val_reg, val_next;
    logic [BW-1:0]               bkt_reg, bkt_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [KW-1:0]               quo_reg, quo_next;
    logic [BW:0]                 rem_reg, rem_next;
    logic [BW-1:0]               clr_reg, clr_next;
    logic [PW-1:0]               p_reg, p_next;
    logic [PW-1:0]               prev_reg, prev_next;
    logic [PW-1:0]               nxt_reg, nxt_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [PW-1:0]               fresh_reg, fresh_next;
    logic [PW-1:0]               free_reg, free_next;
    logic [CBW-1:0]              cb_reg, cb_next;
    logic [PW-1:0]               cnode_reg, cnode_next;
    logic                        res_found_reg, res_found_next;
    logic [VW-1:0]               res_value_reg, res_value_next;
    logic [chte_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [VW-1:0]               result_value_reg, result_value_next;
    logic [chte_pkg::STAT_W-1:0] status_reg, status_next;

    logic          h_we, n_we, kv_we;
    logic [BW-1:0] h_waddr, h_raddr;
    logic [PW-1:0] h_wdata, h_rdata;
    logic [NW-1:0] n_waddr, n_raddr, kv_waddr, kv_raddr;
    logic [PW-1:0] n_wdata, n_rdata;
    logic [KW+VW-1:0] kv_wdata, kv_rdata;
    logic [KW+VW-1:0] recip_prod;
    logic [KW-1:0]    rem_diff;
    logic [CBW-1:0] cb_inc;
    logic          accept;
    logic          out_free;

    chte_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    chte_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    chte_ram #(.WIDTH(KW + VW), .DEPTH(CAPACITY)) u_kv (
        .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
        .raddr(kv_raddr), .rdata(kv_rdata)
    );

    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign recip_prod = {{VW{1'b0}}, key_reg} * {{KW{1'b0}}, RECIP};
    assign rem_diff   = key_reg - quo_reg * BUCKETS_K;
    assign cb_inc     = cb_reg + CBW'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chte_pkg::ST_CLEAR:
            begin
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = chte_pkg::ST_IDLE;
                end
            end
            chte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        chte_pkg::REQ_INSERT, chte_pkg::REQ_RETRIEVE,
                        chte_pkg::REQ_DELETE:
                            state_next = IS_POW2 ? chte_pkg::ST_KEY_START
                                                 : chte_pkg::ST_MOD;
                        chte_pkg::REQ_VISIT, chte_pkg::REQ_NEXT_DUP:
                            state_next = chte_pkg::ST_CUR_ADV;
                        default:
                            state_next = chte_pkg::ST_OUT;
                    endcase
                end
            end
            chte_pkg::ST_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = chte_pkg::ST_KEY_START;
                end
            end
            chte_pkg::ST_KEY_START:
            begin
                state_next = (req_reg == chte_pkg::REQ_INSERT) ? chte_pkg::ST_INS_WR
                                                               : chte_pkg::ST_FIND_HEAD;
            end
            chte_pkg::ST_INS_WR:    state_next = chte_pkg::ST_OUT;
            chte_pkg::ST_FIND_HEAD: state_next = chte_pkg::ST_FIND_ISSUE;
            chte_pkg::ST_FIND_ISSUE:
            begin
                state_next = (p_reg == NIL) ? chte_pkg::ST_OUT : chte_pkg::ST_FIND_CMP;
            end
            chte_pkg::ST_FIND_CMP:
            begin
                if (kv_rdata[KW+VW-1:VW] == key_reg)
                begin
                    state_next = (req_reg == chte_pkg::REQ_DELETE) ? chte_pkg::ST_DEL_LINK
                                                                   : chte_pkg::ST_OUT;
                end
                else
                begin
                    state_next = chte_pkg::ST_FIND_ISSUE;
                end
            end
            chte_pkg::ST_DEL_LINK: state_next = chte_pkg::ST_DEL_FREE;
            chte_pkg::ST_DEL_FREE: state_next = chte_pkg::ST_OUT;
            chte_pkg::ST_CUR_ADV:
            begin
                state_next = (cnode_reg == NIL) ? chte_pkg::ST_CUR_HEAD
                                                : chte_pkg::ST_CUR_LINK;
            end
            chte_pkg::ST_CUR_HEAD: state_next = chte_pkg::ST_CUR_CHECK;
            chte_pkg::ST_CUR_LINK: state_next = chte_pkg::ST_CUR_CHECK;
            chte_pkg::ST_CUR_CHECK:
            begin
                if (cnode_reg == NIL)
                begin
                    state_next = (cb_inc >= CBW'(BUCKETS)) ? chte_pkg::ST_OUT
                                                           : chte_pkg::ST_CUR_HEAD;
                end
                else
                begin
                    state_next = (req_reg == chte_pkg::REQ_VISIT) ? chte_pkg::ST_VIS_DATA
                                                                  : chte_pkg::ST_DUP_DATA;
                end
            end
            chte_pkg::ST_VIS_DATA: state_next = chte_pkg::ST_OUT;
            chte_pkg::ST_DUP_DATA: state_next = chte_pkg::ST_DUP_ISSUE;
            chte_pkg::ST_DUP_ISSUE:
            begin
                state_next = (p_reg == NIL) ? chte_pkg::ST_CUR_CHECK
                                            : chte_pkg::ST_DUP_CMP;
            end
            chte_pkg::ST_DUP_CMP:
            begin
                state_next = (kv_rdata[KW+VW-1:VW] == k_reg) ? chte_pkg::ST_OUT
                                                             : chte_pkg::ST_DUP_ISSUE;
            end
            chte_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = chte_pkg::ST_IDLE;
                end
            end
            default: state_next = chte_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory ports and result registers.
    always_comb
    begin
        req_next          = req_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        bkt_next          = bkt_reg;
        cnt_next          = cnt_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        clr_next          = clr_reg;
        p_next            = p_reg;
        prev_next         = prev_reg;
        nxt_next          = nxt_reg;
        k_next            = k_reg;
        fresh_next        = fresh_reg;
        free_next         = free_reg;
        cb_next           = cb_reg;
        cnode_next        = cnode_reg;
        res_found_next    = res_found_reg;
        res_value_next    = res_value_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        found_next        = found_reg;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        h_we     = 1'b0;
        h_waddr  = bkt_reg;
        h_wdata  = NIL;
        h_raddr  = bkt_reg;
        n_we     = 1'b0;
        n_waddr  = p_reg[NW-1:0];
        n_wdata  = free_reg;
        n_raddr  = p_reg[NW-1:0];
        kv_we    = 1'b0;
        kv_waddr = free_reg[NW-1:0];
        kv_wdata = {key_reg, val_reg};
        kv_raddr = p_reg[NW-1:0];

        unique case (state_reg)
            chte_pkg::ST_CLEAR:
            begin
                h_we     = 1'b1;
                h_waddr  = clr_reg;
                clr_next = clr_reg + BW'(1);
            end
            chte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req_type;
                    key_next        = key;
                    val_next        = value;
                    bkt_next        = IS_POW2 ? key[BW-1:0] : '0;
                    cnt_next        = CW'(2);
                    prev_next       = NIL;
                    res_found_next  = 1'b0;
                    res_value_next  = '0;
                    res_status_next = chte_pkg::STAT_OK;
                    if (req_type == chte_pkg::REQ_RESET_CUR)
                    begin
                        cnode_next = NIL;
                        cb_next    = '0;
                    end
                end
            end
            chte_pkg::ST_MOD:
            begin
                // Quotient estimate, then key minus quotient times BUCKETS, then one fix-up.
                unique case (cnt_reg)
                    CW'(2):
                    begin
                        quo_next = KW'(recip_prod >> SHIFT);
                    end
                    CW'(1):
                    begin
                        rem_next = rem_diff[BW:0];
                    end
                    default:
                    begin
                        bkt_next = (rem_reg >= (BW + 1)'(BUCKETS))
                                   ? BW'(rem_reg - (BW + 1)'(BUCKETS))
                                   : BW'(rem_reg);
                    end
                endcase
                cnt_next = cnt_reg - CW'(1);
            end
            chte_pkg::ST_KEY_START:
            begin
                h_raddr = bkt_reg;
                n_raddr = free_reg[NW-1:0];
            end
            chte_pkg::ST_INS_WR:
            begin
                if (free_reg != NIL || fresh_reg < NIL)
                begin
                    h_we     = 1'b1;
                    n_we     = 1'b1;
                    kv_we    = 1'b1;
                    n_wdata  = h_rdata;
                    if (free_reg != NIL)
                    begin
                        h_wdata   = free_reg;
                        n_waddr   = free_reg[NW-1:0];
                        kv_waddr  = free_reg[NW-1:0];
                        free_next = n_rdata;
                    end
                    else
                    begin
                        h_wdata    = fresh_reg;
                        n_waddr    = fresh_reg[NW-1:0];
                        kv_waddr   = fresh_reg[NW-1:0];
                        fresh_next = fresh_reg + PW'(1);
                    end
                end
                else
                begin
                    res_status_next = chte_pkg::STAT_FULL;
                end
            end
            chte_pkg::ST_FIND_HEAD:
            begin
                p_next = h_rdata;
            end
            chte_pkg::ST_FIND_ISSUE:
            begin
                if (p_reg == NIL)
                begin
                    res_status_next = chte_pkg::STAT_NOT_FOUND;
                end
            end
            chte_pkg::ST_FIND_CMP:
            begin
                if (kv_rdata[KW+VW-1:VW] == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_value_next = kv_rdata[VW-1:0];
                    nxt_next       = n_rdata;
                end
                else
                begin
                    prev_next = p_reg;
                    p_next    = n_rdata;
                end
            end
            chte_pkg::ST_DEL_LINK:
            begin
                if (prev_reg != NIL)
                begin
                    n_we    = 1'b1;
                    n_waddr = prev_reg[NW-1:0];
                    n_wdata = nxt_reg;
                end
                else
                begin
                    h_we    = 1'b1;
                    h_wdata = nxt_reg;
                end
            end
            chte_pkg::ST_DEL_FREE:
            begin
                n_we      = 1'b1;
                n_waddr   = p_reg[NW-1:0];
                n_wdata   = free_reg;
                free_next = p_reg;
            end
            chte_pkg::ST_CUR_ADV:
            begin
                if (cnode_reg == NIL)
                begin
                    cb_next = '0;
                    h_raddr = '0;
                end
                else
                begin
                    n_raddr = cnode_reg[NW-1:0];
                end
            end
            chte_pkg::ST_CUR_HEAD:
            begin
                cnode_next = h_rdata;
            end
            chte_pkg::ST_CUR_LINK:
            begin
                cnode_next = n_rdata;
            end
            chte_pkg::ST_CUR_CHECK:
            begin
                if (cnode_reg == NIL)
                begin
                    if (cb_inc >= CBW'(BUCKETS))
                    begin
                        cb_next         = CBW'(BUCKETS);
                        res_status_next = chte_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        cb_next = cb_inc;
                        h_raddr = cb_inc[BW-1:0];
                    end
                end
                else
                begin
                    kv_raddr = cnode_reg[NW-1:0];
                    n_raddr  = cnode_reg[NW-1:0];
                end
            end
            chte_pkg::ST_VIS_DATA:
            begin
                res_found_next = 1'b1;
                res_value_next = kv_rdata[VW-1:0];
            end
            chte_pkg::ST_DUP_DATA:
            begin
                k_next   = kv_rdata[KW+VW-1:VW];
                nxt_next = n_rdata;
                p_next   = n_rdata;
            end
            chte_pkg::ST_DUP_ISSUE:
            begin
                // End of the later part of the chain: move the cursor on.
                if (p_reg == NIL)
                begin
                    cnode_next = nxt_reg;
                end
            end
            chte_pkg::ST_DUP_CMP:
            begin
                if (kv_rdata[KW+VW-1:VW] == k_reg)
                begin
                    res_found_next = 1'b1;
                    res_value_next = kv_rdata[VW-1:0];
                end
                else
                begin
                    p_next = n_rdata;
                end
            end
            chte_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    found_next        = res_found_reg;
                    result_value_next = res_value_reg;
                    status_next       = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready     = (state_reg == chte_pkg::ST_IDLE);
        out_valid    = out_valid_reg;
        found        = found_reg;
        result_value = result_value_reg;
        status       = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chte_pkg::ST_CLEAR;
            clr_reg       <= '0;
            fresh_reg     <= '0;
            free_reg      <= NIL;
            cb_reg        <= '0;
            cnode_reg     <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fresh_reg     <= fresh_next;
            free_reg      <= free_next;
            cb_reg        <= cb_next;
            cnode_reg     <= cnode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg          <= req_next;
        key_reg          <= key_next;
        val_reg          <= val_next;
        bkt_reg          <= bkt_next;
        cnt_reg          <= cnt_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        p_reg            <= p_next;
        prev_reg         <= prev_next;
        nxt_reg          <= nxt_next;
        k_reg            <= k_next;
        res_found_reg    <= res_found_next;
        res_value_reg    <= res_value_next;
        res_status_reg   <= res_status_next;
        found_reg        <= found_next;
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    `CHTE_ASSERT_NEXT(a_one_in_flight, accept, !in_ready)
    `CHTE_ASSERT_NOW(a_no_accept_in_clear, state_reg == chte_pkg::ST_CLEAR, !in_ready)
    `CHTE_ASSERT_NOW(a_free_was_handed_out, free_reg != NIL, free_reg < fresh_reg)
    `CHTE_ASSERT_NOW(a_fresh_in_range, 1'b1, fresh_reg <= NIL)

endmodule

>>> hdl/chte_ram.sv
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
